// ----- design/spq_pkg.sv -----
// types shared by the sorted minimum priority queue
// used by spq_cell and sorted_min_priority_queue, no dependencies
`default_nettype none

package spq_pkg;

	// input command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [VALUE_W-1:0] value_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic push;   // insert the broadcast value
		logic pop;    // shift everything one place toward the head
	} spq_ctrl_t;

endpackage

`default_nettype wire

// ----- design/spq_cell.sv -----
// one storage cell of the sorted chain: holds a single entry
// depends on spq_pkg
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire        clk,
	input  spq_ctrl_t  ctrl,
	input  value_t     value,        // value being pushed
	input  wire        occupied,     // this cell holds a live entry
	input  value_t     left_entry,   // neighbor nearer the head
	input  wire        left_take,    // neighbor takes the new value or is past it
	input  value_t     right_entry,  // neighbor farther from the head
	output value_t     entry,
	output value_t     entry_next,
	output logic       take
);

	value_t entry_q;

	// insertion point lies at or before this cell
	assign take = !occupied || (entry_q > value);

	// next content of this cell
	always_comb begin
		entry_next = entry_q;
		if (ctrl.push) begin
			if (left_take) begin
				entry_next = left_entry;
			end else if (take) begin
				entry_next = value;
			end
		end else if (ctrl.pop) begin
			entry_next = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_next;
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ----- design/sorted_min_priority_queue.sv -----
// sorted minimum priority queue: a chain of DEPTH cells kept in ascending order
// the result word for an accepted input word is registered directly into the output register
// throughput: one word per cycle while the output is not stalled; every cell compares and shifts in parallel each cycle
// s_tready is high whenever the output register is free or being taken this cycle
// reset clears the entry count and the output valid; cell contents are not cleared
// depends on spq_pkg and spq_cell
`default_nettype none

module sorted_min_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // value[31:0]
	input  wire  [0:0]  s_tuser,   // command[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // smallest[31:0]
	output logic [6:0]  m_tuser    // empty_res[0], count[5:1], dropped[6]
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          m_tvalid_q;
	value_t        smallest_q;
	logic          empty_q;
	logic [COUNT_W-1:0] count_out_q;
	logic          dropped_q;

	logic      in_acc;
	logic      is_push;
	logic      full;
	logic      empty;
	spq_ctrl_t ctrl;
	value_t    value;

	value_t entry [DEPTH];
	value_t entry_next [DEPTH];
	logic   take [DEPTH];

	// handshake
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	assign value   = $signed(s_tdata);
	assign is_push = (s_tuser[0] == CMD_PUSH);
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);

	// control broadcast to the chain
	assign ctrl.push = in_acc && is_push && !full;
	assign ctrl.pop  = in_acc && !is_push && !empty;

	always_comb begin
		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_next = count_q - 1'b1;
		end
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t left_e;
		value_t right_e;
		logic   left_t;
		if (i == 0) begin : g_head
			assign left_e = entry[0];
			assign left_t = 1'b0;
		end else begin : g_mid
			assign left_e = entry[i-1];
			assign left_t = take[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_e = entry[i];
		end else begin : g_body
			assign right_e = entry[i+1];
		end
		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.value       (value),
			.occupied    (count_q > CW'(i)),
			.left_entry  (left_e),
			.left_take   (left_t),
			.right_entry (right_e),
			.entry       (entry[i]),
			.entry_next  (entry_next[i]),
			.take        (take[i])
		);
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result word register
	logic [CW+COUNT_W-1:0] count_ext;
	assign count_ext = {{COUNT_W{1'b0}}, count_next};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smallest_q  <= (count_next == '0) ? '0 : entry_next[0];
			empty_q     <= (count_next == '0);
			count_out_q <= count_ext[COUNT_W-1:0];
			dropped_q   <= is_push && full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = smallest_q;
	assign m_tuser  = {dropped_q, count_out_q, empty_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_push && full) |=> (m_tuser[6] && count_q == CW'(DEPTH)))
		else $error("drop flag without full queue");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc) |-> (m_tuser[0] == (count_q == '0)))
		else $error("empty flag disagrees with count");

endmodule

`default_nettype wire
